FILE: src/ptr_pkg.sv
// Shared types and constants for the polar to rectangular CORDIC pipeline.
// Used by ptr_pre, ptr_cell, ptr_post and polar_to_rectangular_iq.
package ptr_pkg;

  // One rotation cell per CORDIC iteration.
  localparam int unsigned NUM_CELLS = 30;

  // The amplitude is aligned to Q31 and scaled to Q39, so the datapath widths do not
  // depend on the sample width.
  localparam int unsigned XY_WIDTH = 42;
  localparam int unsigned Z_WIDTH  = 33;

  // Inverse CORDIC gain, 0.60725293500888 in Q30.
  localparam logic [30:0] GAIN_INV = 31'd652032874;

  // atan(2^-i) as a fraction of a 32-bit full turn.
  localparam logic [31:0] ATAN_TURN [NUM_CELLS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // Data handed from one pipeline stage to the next.
  typedef struct packed {
    logic [1:0]                 quad;
    logic signed [XY_WIDTH-1:0] x;
    logic signed [XY_WIDTH-1:0] y;
    logic signed [Z_WIDTH-1:0]  z;
  } rot_t;

endpackage

FILE: src/ptr_pre.sv
// Input stage: gain compensation multiply and angle split into quadrant and residual.
// Depends on ptr_pkg.
module ptr_pre #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned ANGLE_WIDTH  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [SAMPLE_WIDTH-1:0] magnitude_i,
  input  logic [ANGLE_WIDTH-1:0]         phase_i,
  output logic                           valid_o,
  output ptr_pkg::rot_t                  data_o
);

  localparam int unsigned PROD_WIDTH = SAMPLE_WIDTH + 31;

  logic signed [PROD_WIDTH-1:0] prod_d, prod_q;
  logic [31:0]                  angle;
  logic [1:0]                   quad_q;
  logic [29:0]                  resid_q;
  logic                         valid_q;
  logic signed [63:0]           x_wide;

  always_comb begin
    prod_d = magnitude_i * $signed(ptr_pkg::GAIN_INV);
    angle  = 32'(phase_i) << (32 - ANGLE_WIDTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      quad_q  <= angle[31:30];
      resid_q <= angle[29:0];
    end
  end

  // Align the product to Q31 times Q30, then drop 22 bits with floor to reach Q39.
  always_comb begin
    x_wide      = 64'(prod_q);
    x_wide      = (x_wide <<< (32 - SAMPLE_WIDTH)) >>> 22;
    data_o.quad = quad_q;
    data_o.x    = ptr_pkg::XY_WIDTH'(x_wide);
    data_o.y    = '0;
    data_o.z    = ptr_pkg::Z_WIDTH'(resid_q);
  end

  assign valid_o = valid_q;

endmodule

FILE: src/ptr_cell.sv
// One CORDIC rotation-mode iteration with its pipeline register.
// Depends on ptr_pkg.
module ptr_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  ptr_pkg::rot_t data_i,
  output logic          valid_o,
  output ptr_pkg::rot_t data_o
);

  logic signed [ptr_pkg::XY_WIDTH-1:0] x_in, y_in, dx, dy;
  logic signed [ptr_pkg::Z_WIDTH-1:0]  z_in, step;
  ptr_pkg::rot_t                       data_d, data_q;
  logic                                valid_q;

  always_comb begin
    x_in   = data_i.x;
    y_in   = data_i.y;
    z_in   = data_i.z;
    dx     = y_in >>> IDX;
    dy     = x_in >>> IDX;
    step   = $signed(ptr_pkg::Z_WIDTH'(ptr_pkg::ATAN_TURN[IDX]));
    data_d = data_i;
    if (!z_in[ptr_pkg::Z_WIDTH-1]) begin
      data_d.x = x_in - dx;
      data_d.y = y_in + dy;
      data_d.z = z_in - step;
    end else begin
      data_d.x = x_in + dx;
      data_d.y = y_in - dy;
      data_d.z = z_in + step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: src/ptr_post.sv
// Output stage: quadrant unfold, round half up, saturate and the output register.
// Depends on ptr_pkg.
module ptr_post #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  ptr_pkg::rot_t                  data_i,
  output logic                           valid_o,
  output logic signed [SAMPLE_WIDTH-1:0] sine_o,
  output logic signed [SAMPLE_WIDTH-1:0] cosine_o
);

  localparam int unsigned RW    = ptr_pkg::XY_WIDTH + 1;
  localparam int unsigned SHIFT = 40 - SAMPLE_WIDTH;
  localparam logic signed [RW-1:0] ROUND = RW'(1) << (SHIFT - 1);
  localparam logic signed [RW-1:0] HI    = (RW'(1) << (SAMPLE_WIDTH - 1)) - RW'(1);
  localparam logic signed [RW-1:0] LO    = ~HI;

  localparam logic [1:0] QUAD_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD  = 2'd2;
  localparam logic [1:0] QUAD_FOURTH = 2'd3;

  logic signed [RW-1:0]           c, s, so, co;
  logic signed [SAMPLE_WIDTH-1:0] sine_d, cosine_d, sine_q, cosine_q;
  logic                           valid_q;

  function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
    input logic signed [RW-1:0] v
  );
    logic signed [RW-1:0] r;
    r = (v + ROUND) >>> SHIFT;
    if (r > HI) begin
      r = HI;
    end else if (r < LO) begin
      r = LO;
    end
    return SAMPLE_WIDTH'(r);
  endfunction

  always_comb begin
    c = RW'(data_i.x);
    s = RW'(data_i.y);
    case (data_i.quad)
      QUAD_FIRST: begin
        so = s;
        co = c;
      end
      QUAD_SECOND: begin
        so = c;
        co = -s;
      end
      QUAD_THIRD: begin
        so = -s;
        co = -c;
      end
      QUAD_FOURTH: begin
        so = -c;
        co = s;
      end
      default: begin
        so = s;
        co = c;
      end
    endcase
    sine_d   = round_sat(so);
    cosine_d = round_sat(co);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sine_q   <= sine_d;
      cosine_q <= cosine_d;
    end
  end

  assign valid_o  = valid_q;
  assign sine_o   = sine_q;
  assign cosine_o = cosine_q;

endmodule

FILE: src/polar_to_rectangular_iq.sv
// Top level of the polar to rectangular converter: input stage, a row of CORDIC cells and
// the output stage. Depends on ptr_pkg, ptr_pre, ptr_cell and ptr_post.
//
// Usage:
//   Input channel: in_valid_i with magnitude_i (signed Q1.(SAMPLE_WIDTH-1)) and phase_i
//   (binary angle, 2^ANGLE_WIDTH is one turn). A transaction happens on a rising edge with
//   in_valid_i high and in_stall_o low.
//   Output channel: out_valid_o with sine_part_o and cosine_part_o, magnitude times sine
//   and cosine of the phase, rounded and saturated to Q1.(SAMPLE_WIDTH-1).
//   Pipeline: a result passes the input multiply stage, 30 CORDIC cells and the output
//   register, in that order, before it is presented.
//   Throughput: one transaction per clock unless stalled; every cell advances in step.
//   Stall: while the output register holds a result and out_stall_i is high, the whole
//   row freezes and in_stall_o is raised; it falls as soon as the result is taken or the
//   output register is empty.
//   Reset: rst_ni clears all valid flags asynchronously; no results are pending after it
//   and no start-up sweep is needed.
module polar_to_rectangular_iq #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned ANGLE_WIDTH  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] magnitude_i,
  input  logic [ANGLE_WIDTH-1:0]         phase_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] sine_part_o,
  output logic signed [SAMPLE_WIDTH-1:0] cosine_part_o
);

  logic                          pipe_en;
  logic [ptr_pkg::NUM_CELLS:0]   cell_valid;
  ptr_pkg::rot_t                 cell_data [ptr_pkg::NUM_CELLS+1];

  // The row moves whenever the output register is empty or being emptied.
  assign pipe_en    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !pipe_en;

  ptr_pre #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_pre (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .valid_i    (in_valid_i),
    .magnitude_i(magnitude_i),
    .phase_i    (phase_i),
    .valid_o    (cell_valid[0]),
    .data_o     (cell_data[0])
  );

  for (genvar i = 0; i < ptr_pkg::NUM_CELLS; i++) begin : g_cell
    ptr_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (pipe_en),
      .valid_i(cell_valid[i]),
      .data_i (cell_data[i]),
      .valid_o(cell_valid[i+1]),
      .data_o (cell_data[i+1])
    );
  end

  ptr_post #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (cell_valid[ptr_pkg::NUM_CELLS]),
    .data_i  (cell_data[ptr_pkg::NUM_CELLS]),
    .valid_o (out_valid_o),
    .sine_o  (sine_part_o),
    .cosine_o(cosine_part_o)
  );

`ifndef NO_ASSERTIONS
  // The input side is only held off by a result that is waiting at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // A frozen row keeps every item where it is.
  a_row_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(cell_valid))
    else $error("cell valid flags moved during a stall");

  // An accepted transaction reaches the input register in the next cycle.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> cell_valid[0])
    else $error("accepted transaction lost at the input stage");

  // The last cell's item is moved into the output register when the row advances.
  a_output_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_en && cell_valid[ptr_pkg::NUM_CELLS]) |=> out_valid_o)
    else $error("result from the last cell was dropped");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for polar_to_rectangular_iq, the CORDIC polar to rectangular stage.
// It depends only on the RTL: an in-line fixed-point model predicts sine and cosine parts.
module testbench;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PHASE_W  = 16;
  localparam int unsigned ROTATIONS = 30;
  localparam longint INV_GAIN_Q30 = 64'sd652032874;
  localparam int unsigned RESULT_LATENCY = 31;

  // atan(2^-i) expressed as a fraction of a 32-bit turn.
  localparam logic [31:0] ROTATION_ANGLE [ROTATIONS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef enum logic [1:0] {
    QUAD_FIRST,
    QUAD_SECOND,
    QUAD_THIRD,
    QUAD_FOURTH
  } quadrant_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sine_part;
    logic signed [SAMPLE_W-1:0] cosine_part;
  } rect_sample_t;

  logic                       clk_i;
  logic                       rst_ni       = 1'b0;
  logic                       in_valid_i   = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] magnitude_i  = '0;
  logic [PHASE_W-1:0]         phase_i      = '0;
  logic                       out_valid_o;
  logic                       out_stall_i  = 1'b0;
  logic signed [SAMPLE_W-1:0] sine_part_o;
  logic signed [SAMPLE_W-1:0] cosine_part_o;

  rect_sample_t expected_rect_q [$];
  int unsigned  sender_idle_pct   = 0;
  int unsigned  receiver_idle_pct = 0;
  int unsigned  error_count       = 0;
  int unsigned  results_checked   = 0;
  int unsigned  directed_sent     = 0;
  int unsigned  random_sent       = 0;

  polar_to_rectangular_iq #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .ANGLE_WIDTH (PHASE_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .magnitude_i  (magnitude_i),
    .phase_i      (phase_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sine_part_o  (sine_part_o),
    .cosine_part_o(cosine_part_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Rounds a Q39 value half up to Q1.15 and clamps it to the output range.
  function automatic logic signed [SAMPLE_W-1:0] round_to_q15(longint v);
    longint r;
    r = (v + (longint'(1) <<< 23)) >>> 24;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[SAMPLE_W-1:0];
  endfunction

  function automatic rect_sample_t polar_to_rect(logic signed [SAMPLE_W-1:0] mag,
                                                 logic [PHASE_W-1:0] ph);
    rect_sample_t res;
    quadrant_e    quadrant;
    longint       amp, x, y, z, dx, dy, sin_v, cos_v;
    int           i;
    quadrant = quadrant_e'(ph[PHASE_W-1 -: 2]);
    z   = {34'd0, ph[PHASE_W-3:0], 16'd0};
    amp = longint'(mag) <<< (32 - SAMPLE_W);
    x   = (amp * INV_GAIN_Q30) >>> 22;
    y   = 0;
    for (i = 0; i < ROTATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ROTATION_ANGLE[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ROTATION_ANGLE[i]);
      end
    end
    case (quadrant)
      QUAD_FIRST: begin
        sin_v = y;
        cos_v = x;
      end
      QUAD_SECOND: begin
        sin_v = x;
        cos_v = -y;
      end
      QUAD_THIRD: begin
        sin_v = -y;
        cos_v = -x;
      end
      default: begin
        sin_v = -x;
        cos_v = y;
      end
    endcase
    res.sine_part   = round_to_q15(sin_v);
    res.cosine_part = round_to_q15(cos_v);
    return res;
  endfunction

  // Offers one sample, with random idle cycles ahead of it, and records its prediction
  // once the transaction has taken place.
  task automatic send_sample(logic signed [SAMPLE_W-1:0] mag, logic [PHASE_W-1:0] ph);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    magnitude_i <= mag;
    phase_i     <= ph;
    do @(posedge clk_i); while (in_stall_o);
    expected_rect_q.push_back(polar_to_rect(mag, ph));
  endtask

  // Holds the sender back until every outstanding result has been checked.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_rect_q.size() != 0) @(posedge clk_i);
  endtask

  // Result side: random stalls, and each result is compared with the oldest prediction.
  always @(posedge clk_i) begin
    rect_sample_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rect_q.size() == 0) begin
        $error("result with no transaction outstanding: sine_part %0d cosine_part %0d",
               sine_part_o, cosine_part_o);
        error_count++;
      end else begin
        want = expected_rect_q.pop_front();
        results_checked++;
        if (sine_part_o !== want.sine_part) begin
          $error("sine_part mismatch: expected %0d, actual %0d", want.sine_part, sine_part_o);
          error_count++;
        end
        if (cosine_part_o !== want.cosine_part) begin
          $error("cosine_part mismatch: expected %0d, actual %0d",
                 want.cosine_part, cosine_part_o);
          error_count++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
  end

  task automatic test_positive_full_scale();
    logic [PHASE_W-1:0] angles [6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000,
                                       16'hFFFF};
    foreach (angles[n]) begin
      send_sample(16'sh7FFF, angles[n]);
      directed_sent++;
    end
  endtask

  // A magnitude of -1.0 turned onto a positive axis must clamp to the top code.
  task automatic test_full_negative_scale();
    logic [PHASE_W-1:0] angles [6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h0001,
                                       16'h7FFF};
    foreach (angles[n]) begin
      send_sample(16'sh8000, angles[n]);
      directed_sent++;
    end
  endtask

  task automatic test_small_amplitudes();
    logic signed [SAMPLE_W-1:0] mags   [5] = '{16'sh0000, 16'sh0001, 16'shFFFF, 16'sh5555,
                                               16'shAAAA};
    logic [PHASE_W-1:0]         angles [5] = '{16'h1234, 16'h6000, 16'hA000, 16'h3FFF,
                                               16'hBFFF};
    foreach (mags[n]) begin
      send_sample(mags[n], angles[n]);
      directed_sent++;
    end
  endtask

  // Uniform samples for half the draws, with full-scale amplitudes and angles close to the
  // quadrant boundaries for the rest.
  task automatic send_random_samples(int unsigned count);
    logic signed [SAMPLE_W-1:0] mag;
    logic [PHASE_W-1:0]         ph;
    repeat (count) begin
      mag = SAMPLE_W'($urandom);
      ph  = PHASE_W'($urandom);
      case ($urandom_range(3))
        1: mag = $urandom_range(1) ? 16'sh7FFF - SAMPLE_W'($urandom_range(2))
                                   : 16'sh8000 + SAMPLE_W'($urandom_range(2));
        2: ph = {2'($urandom_range(3)), 14'd0} + PHASE_W'($urandom_range(8)) - 16'd4;
        default: ;
      endcase
      send_sample(mag, ph);
      random_sent++;
    end
  endtask

  task automatic test_random_slow_receiver();
    sender_idle_pct   = 35;
    receiver_idle_pct = 74;
    send_random_samples(230);
  endtask

  task automatic test_random_slow_sender();
    sender_idle_pct   = 74;
    receiver_idle_pct = 35;
    send_random_samples(230);
  endtask

  task automatic test_random_streaming();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    send_random_samples(240);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_positive_full_scale();
    test_full_negative_scale();
    test_small_amplitudes();
    wait_drained();
    test_random_slow_receiver();
    wait_drained();
    test_random_slow_sender();
    wait_drained();
    test_random_streaming();
    wait_drained();
    repeat (RESULT_LATENCY + 10) @(posedge clk_i);

    $display("Run covered %0d directed and %0d random samples under three stall mixes.",
             directed_sent, random_sent);
    $display("%0d results compared, %0d mismatches found.", results_checked, error_count);
    if (error_count == 0 && expected_rect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
src/ptr_pkg.sv
src/ptr_pre.sv
src/ptr_cell.sv
src/ptr_post.sv
src/polar_to_rectangular_iq.sv
tb/testbench.sv
